FILE: hw/rtl/nibble_trie_key_set_assert.svh
// Assertion macros used by the checker of the key set.
`ifndef NIBBLE_TRIE_KEY_SET_ASSERT_SVH
`define NIBBLE_TRIE_KEY_SET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTKS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("key set check failed");

// The consequent must hold in the cycle after the antecedent.
`define NTKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("key set check failed");

// As above, but also checked while reset is applied.
`define NTKS_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("key set reset check failed");

`endif

FILE: hw/rtl/ntks_pkg.sv
`default_nettype none

package ntks_pkg;

    // Trie geometry.
    localparam int NODE_COUNT = 1024;
    localparam int LEVELS     = 4;
    localparam int FANOUT     = 16;

    localparam int KEY_W    = 16;
    localparam int NIB_W    = $clog2(FANOUT);
    localparam int KEY_NIBS = KEY_W / NIB_W;
    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W   = NODE_W + NIB_W;
    localparam int DEPTH    = NODE_COUNT * FANOUT;
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [NIB_W-1:0]  t_nib;
    typedef logic [NODE_W-1:0] t_link;
    typedef logic [FREE_W-1:0] t_free;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LVL_W-1:0]  t_level;

    // Operation codes.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // A last-level link holds this mark once the key is present.
    localparam t_link PRESENT_MARK = t_link'(1);

    // Access to the link store from the walker.
    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        t_addr addr;
        t_link wr_data;
    } t_store_req;

    // Nibble of the key used at a level; levels above the key read as zero.
    function automatic t_nib nibble_at(t_key key, t_level level);
        t_nib nib;
        nib = '0;
        for (int i = 0; i < KEY_NIBS; i++) begin
            if (int'(level) == i) begin
                nib = key[i*NIB_W +: NIB_W];
            end
        end
        return nib;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ntks_chan_if.sv
`default_nettype none

// Request channel: one item carries an operation and a key.
interface ntks_req_if import ntks_pkg::*; ();
    logic valid;
    logic ready;
    logic func;
    t_key key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

// Response channel: one item carries the lookup outcome.
interface ntks_rsp_if import ntks_pkg::*; ();
    logic valid;
    logic ready;
    logic found;
    logic pool_full;

    modport source (output valid, output found, output pool_full, input ready);
    modport sink   (input valid, input found, input pool_full, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ntks_link_store.sv
`default_nettype none

module ntks_link_store import ntks_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_store_req i_req,
    output t_link      o_rd_data,
    output logic       o_clearing
);

    t_link mem [DEPTH];
    t_link r_rd_data;
    t_addr r_clr_addr;
    logic  r_clearing;

    // Clearing sweep: one entry per cycle from reset until the last entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Single write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

FILE: hw/rtl/nibble_trie_key_set.sv
// A set of 16-bit keys held as a radix trie with a 4-bit stride, low nibble first, in one
// node memory of 1024 nodes with 16 links each. Each request item inserts a key or asks
// whether it is present, and gives exactly one response item: found reports whether the key
// was present before the item, pool_full that an insert ran out of nodes (partial paths stay
// linked, no mark is written). After reset the block clears the whole link memory, one entry
// a cycle, so it takes no request until the sweep is done. An item then walks up to four
// levels, one at a time, each a read of the single-port node memory, then the decision and
// any write-back, and after the walk hands the result to the output register; a query that
// misses early finishes sooner. The next request is taken while a response still waits in
// the output register.
`default_nettype none

module nibble_trie_key_set import ntks_pkg::*; (
    input  wire i_clk,
    input  wire i_rst_n,
    ntks_req_if.sink   i_in,
    ntks_rsp_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    t_level     r_level, n_level;
    t_free      r_free, n_free;
    logic       r_out_valid, n_out_valid;
    logic       r_func, n_func;
    t_key       r_key, n_key;
    t_link      r_node, n_node;
    logic       r_found, n_found;
    logic       r_full, n_full;
    logic       r_out_found, n_out_found;
    logic       r_out_full, n_out_full;

    t_store_req w_req;
    t_link      w_rd_data;
    logic       w_clearing;
    logic       w_in_acc;
    logic       w_out_acc;

    ntks_link_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rd_data  (w_rd_data),
        .o_clearing (w_clearing)
    );

    // Handshakes.
    assign i_in.ready      = (r_state == S_IDLE) && !w_clearing;
    assign w_in_acc        = i_in.valid && i_in.ready;
    assign w_out_acc       = r_out_valid && o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.found     = r_out_found;
    assign o_out.pool_full = r_out_full;

    // Trie walk: read a link, then follow, allocate or finish.
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_free      = r_free;
        n_func      = r_func;
        n_key       = r_key;
        n_node      = r_node;
        n_found     = r_found;
        n_full      = r_full;
        n_out_found = r_out_found;
        n_out_full  = r_out_full;
        n_out_valid = r_out_valid && !w_out_acc;

        w_req         = '0;
        w_req.addr    = {r_node, nibble_at(r_key, r_level)};
        w_req.wr_data = PRESENT_MARK;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_func  = i_in.func;
                    n_key   = i_in.key;
                    n_node  = '0;
                    n_level = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                w_req.rd_en = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (r_level == LVL_W'(LEVELS - 1)) begin
                    // Last level: the link is only a presence mark.
                    n_found = (w_rd_data != '0);
                    n_full  = 1'b0;
                    if ((w_rd_data == '0) && (r_func == FUNC_INSERT)) begin
                        w_req.wr_en = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (w_rd_data == '0) begin
                    n_found = 1'b0;
                    if (r_func == FUNC_QUERY) begin
                        n_full  = 1'b0;
                        n_state = S_DONE;
                    end else if (r_free >= FREE_W'(NODE_COUNT)) begin
                        n_full  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        // Allocate the next free node and link it in.
                        w_req.wr_en   = 1'b1;
                        w_req.wr_data = r_free[NODE_W-1:0];
                        n_node        = r_free[NODE_W-1:0];
                        n_free        = r_free + FREE_W'(1);
                        n_level       = r_level + LVL_W'(1);
                        n_state       = S_LOOK;
                    end
                end else begin
                    n_node  = w_rd_data;
                    n_level = r_level + LVL_W'(1);
                    n_state = S_LOOK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_found = r_found;
                    n_out_full  = r_full;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_free      <= FREE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_key       <= n_key;
        r_node      <= n_node;
        r_found     <= n_found;
        r_full      <= n_full;
        r_out_found <= n_out_found;
        r_out_full  <= n_out_full;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ntks_checker.sv
`default_nettype none

`include "nibble_trie_key_set_assert.svh"

module ntks_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_out_found,
    input wire i_out_pool_full
);

    // A waiting response keeps its valid and its payload.
    `NTKS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_found) && $stable(i_out_pool_full))

    // A key is only reported present at the last level, where no node is allocated.
    `NTKS_ASSERT_SAME(a_found_not_full, i_clk, i_rst_n, i_out_valid, !(i_out_found && i_out_pool_full))

    // One item at a time: the walk starts at once after an accept.
    `NTKS_ASSERT_NEXT(a_one_walk, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // Reset leaves no response and starts the clearing sweep.
    `NTKS_ASSERT_RESET(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid && !i_in_ready)

endmodule

bind nibble_trie_key_set ntks_checker u_ntks_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_found     (o_out.found),
    .i_out_pool_full (o_out.pool_full)
);

`default_nettype wire
